// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define PTP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An implication checked at every clock edge outside of reset.
`define PTP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define PTP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptp_pkg
// Types and constants shared by the puck trajectory predictor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

    // Datapath widths of the serial arithmetic units, the core and the port.
    localparam int MA_W    = 22;  // multiplicand, signed
    localparam int MB_W    = 12;  // multiplier, signed, consumed two bits a cycle
    localparam int P_W     = 34;  // product and dividend, signed
    localparam int DV_W    = 21;  // divisor, signed
    localparam int DIV_DIG = 2;   // quotient bits per divider cycle
    localparam int CRD_W   = 12;  // coordinate width
    localparam int V_W     = 13;  // motion vector width
    localparam int SPD_W   = 20;  // unsaturated speed width
    localparam int PADDR_W = 5;

    // Geometry and thresholds.
    localparam int WALL_LEFT    = 38;
    localparam int WALL_RIGHT   = 562;
    localparam int ROBOT_CX     = 300;
    localparam int ROBOT_CY     = 500;
    localparam int NOISE_LIM    = 100;
    localparam int APPROACH_LIM = -50;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_CPX = 3'd0;
    localparam logic [2:0] REG_CPY = 3'd1;
    localparam logic [2:0] REG_SCY = 3'd2;
    localparam logic [2:0] REG_SCX = 3'd3;
    localparam logic [2:0] REG_DEF = 3'd4;
    localparam logic [2:0] REG_FMS = 3'd5;

    // Result status codes.
    localparam logic [2:0] ST_NOISE  = 3'd0;
    localparam logic [2:0] ST_AWAY   = 3'd1;
    localparam logic [2:0] ST_DIRECT = 3'd2;
    localparam logic [2:0] ST_ONE    = 3'd3;
    localparam logic [2:0] ST_TWO    = 3'd4;

    typedef struct packed {
        logic [9:0] center_px_x;
        logic [9:0] center_px_y;
        logic [9:0] scale_y_q8;
        logic [9:0] scale_x_q8;
        logic [9:0] defense_line;
        logic [7:0] frame_ms;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_MX, S_MY, S_SX, S_DSX, S_SY, S_DSY, S_DEC,
        S_P1, S_P2, S_P3, S_PSEL,
        S_B1, S_B2, S_B3, S_C1, S_C2, S_C3, S_C4, S_C5, S_CSEL,
        S_T1, S_T2, S_DONE
    } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptp_mul.sv =====
// ----------------------------------------------------------------------------
// ptp_mul
// Serial signed multiplier: the multiplier operand is shifted out two bits
// a cycle and the partial products are accumulated on magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_mul (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ptp_pkg::MA_W-1:0]   a,
    input  wire logic signed [ptp_pkg::MB_W-1:0]   b,
    output logic                                   busy,
    output logic signed [ptp_pkg::P_W-1:0]         p
);
    import ptp_pkg::*;

    localparam int STEPS = (MB_W + 1) / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   a_sh_reg;
    logic [MB_W-1:0]  b_sh_reg;
    logic [P_W-1:0]   acc_reg;
    logic             neg_reg;
    logic [MA_W-1:0]  a_mag;
    logic [MB_W-1:0]  b_mag;
    logic [P_W-1:0]   part;

    // Operand magnitudes and the partial product of one digit.
    always_comb
    begin
        a_mag = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
        b_mag = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
        part  = (b_sh_reg[0] ? a_sh_reg : '0)
              + (b_sh_reg[1] ? {a_sh_reg[P_W-2:0], 1'b0} : '0);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // Shift and accumulate.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg <= P_W'(a_mag);
            b_sh_reg <= b_mag;
            acc_reg  <= '0;
            neg_reg  <= a[MA_W-1] ^ b[MB_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= {a_sh_reg[P_W-3:0], 2'b00};
            b_sh_reg <= {2'b00, b_sh_reg[MB_W-1:2]};
        end
    end

    assign busy = busy_reg;
    assign p    = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

`default_nettype wire

// ===== rtl/core/ptp_div.sv =====
// ----------------------------------------------------------------------------
// ptp_div
// Serial signed divider: restoring division on magnitudes, two quotient
// bits a cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ptp_pkg::P_W-1:0]    n,
    input  wire logic signed [ptp_pkg::DV_W-1:0]   d,
    output logic                                   busy,
    output logic signed [ptp_pkg::P_W-1:0]         q
);
    import ptp_pkg::*;

    localparam int STEPS = P_W / DIV_DIG;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   num_reg;
    logic [DV_W-1:0]  rem_reg;
    logic [DV_W-1:0]  den_reg;
    logic             neg_reg;
    logic [DV_W:0]    r;
    logic [P_W-1:0]   nm;

    // Two restoring steps per cycle.
    always_comb
    begin
        r  = {1'b0, rem_reg};
        nm = num_reg;
        for (int i = 0; i < DIV_DIG; i++)
        begin
            r  = {r[DV_W-1:0], nm[P_W-1]};
            nm = {nm[P_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r     = r - {1'b0, den_reg};
                nm[0] = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // Dividend shifts out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= n[P_W-1] ? P_W'(-n) : P_W'(n);
            den_reg <= d[DV_W-1] ? DV_W'(-d) : DV_W'(d);
            rem_reg <= '0;
            neg_reg <= n[P_W-1] ^ d[DV_W-1];
        end
        else if (busy_reg)
        begin
            num_reg <= nm;
            rem_reg <= r[DV_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign q    = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

`default_nettype wire

// ===== rtl/core/ptp_regs.sv =====
// ----------------------------------------------------------------------------
// ptp_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output ptp_pkg::cfg_t                      cfg
);
    import ptp_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_px_x  <= 10'd320;
            cfg_reg.center_px_y  <= 10'd240;
            cfg_reg.scale_y_q8   <= 10'd358;
            cfg_reg.scale_x_q8   <= 10'd358;
            cfg_reg.defense_line <= 10'd100;
            cfg_reg.frame_ms     <= 8'd16;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_CPX: cfg_reg.center_px_x  <= pwdata[9:0];
                REG_CPY: cfg_reg.center_px_y  <= pwdata[9:0];
                REG_SCY: cfg_reg.scale_y_q8   <= pwdata[9:0];
                REG_SCX: cfg_reg.scale_x_q8   <= pwdata[9:0];
                REG_DEF: cfg_reg.defense_line <= pwdata[9:0];
                REG_FMS: cfg_reg.frame_ms     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (idx)
            REG_CPX: prdata = 32'(cfg_reg.center_px_x);
            REG_CPY: prdata = 32'(cfg_reg.center_px_y);
            REG_SCY: prdata = 32'(cfg_reg.scale_y_q8);
            REG_SCX: prdata = 32'(cfg_reg.scale_x_q8);
            REG_DEF: prdata = 32'(cfg_reg.defense_line);
            REG_FMS: prdata = 32'(cfg_reg.frame_ms);
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/puck_trajectory_predictor_core.sv =====
// ----------------------------------------------------------------------------
// puck_trajectory_predictor_core
// Maps a puck pixel position to table millimetres, tracks its motion and
// predicts where it crosses the defense line.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid, in_stall, pix_x, pix_y) carries
//   one detected position per frame. Exactly one result request follows on
//   the output channel (out_valid, out_stall, status and the eight fields).
//   Configuration must be written over the APB-style port while the core is
//   idle; the core itself does not enforce this. All products and quotients
//   go through one serial multiplier (two bits a cycle) and one serial
//   divider (two quotient bits a cycle); a request takes a chain of up to
//   12 products and 7 quotients. One request is worked on at a time, so the
//   next one is taken in the cycle after a result is loaded.
//   A finished result sits in the output register; the next input request is
//   taken meanwhile, and while out_stall is high a newer result waits in the
//   core and in_stall stays high. Reset clears the previous position, the
//   running average and the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module puck_trajectory_predictor_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [9:0]                    pix_x,
    input  wire logic [9:0]                    pix_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic signed [11:0]                 coord_x,
    output logic signed [11:0]                 coord_y,
    output logic signed [15:0]                 speed_x,
    output logic signed [15:0]                 speed_y,
    output logic signed [15:0]                 impact_x,
    output logic signed [15:0]                 impact_time,
    output logic [9:0]                         wall_x,
    output logic signed [15:0]                 wall_y
);
    import ptp_pkg::*;

    localparam logic signed [P_W-1:0] BASE_X = P_W'(ROBOT_CX * 256);
    localparam logic signed [P_W-1:0] BASE_Y = P_W'(ROBOT_CY * 256);
    localparam logic signed [P_W-1:0] WL     = P_W'(WALL_LEFT);
    localparam logic signed [P_W-1:0] WR     = P_W'(WALL_RIGHT);
    localparam logic signed [V_W-1:0] NL_P   = V_W'(NOISE_LIM);
    localparam logic signed [V_W-1:0] NL_N   = V_W'(-NOISE_LIM);
    localparam logic signed [SPD_W-1:0] APL  = SPD_W'(APPROACH_LIM);
    localparam logic signed [MB_W-1:0] HUNDRED = MB_W'(100);

    // Saturate to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] v);
        logic signed [15:0] res;
        if (v < -P_W'(32768))
            res = -16'sd32768;
        else if (v > P_W'(32767))
            res = 16'sd32767;
        else
            res = v[15:0];
        return res;
    endfunction

    // Millimetres from a Q8 product, truncated toward zero and saturated.
    function automatic logic signed [CRD_W-1:0] to_mm(
        input logic signed [P_W-1:0] prod,
        input logic signed [P_W-1:0] base
    );
        logic signed [P_W-1:0]   num;
        logic signed [P_W-1:0]   adj;
        logic signed [P_W-1:0]   sh;
        logic signed [CRD_W-1:0] res;
        num = base - prod;
        adj = num[P_W-1] ? num + P_W'(255) : num;
        sh  = adj >>> 8;
        if (sh < -P_W'(2048))
            res = -12'sd2048;
        else if (sh > P_W'(2047))
            res = 12'sd2047;
        else
            res = sh[CRD_W-1:0];
        return res;
    endfunction

    cfg_t                    cfg;
    seq_state_t              state_reg, state_next, nxt;
    logic                    issued_reg;
    logic                    use_mul, use_div, op_done;
    logic                    mul_start, div_start, mul_busy, div_busy;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   mul_p;
    logic signed [P_W-1:0]   div_n;
    logic signed [DV_W-1:0]  div_d;
    logic signed [P_W-1:0]   div_q;

    logic [9:0]              pix_x_reg, pix_y_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg, prev_x_reg, prev_y_reg, cy_new;
    logic signed [V_W-1:0]   vx_reg, vy_reg;
    logic signed [SPD_W-1:0] spx_reg, spy_reg;
    logic signed [P_W-1:0]   tmp_reg, px_reg, t1_reg;
    logic signed [MA_W-1:0]  by_reg;
    logic [9:0]              wx_reg;
    logic                    bounce_reg;
    logic [2:0]              res_status_reg;
    logic signed [15:0]      res_ix_reg, res_it_reg;
    logic                    avg_valid_reg;
    logic signed [15:0]      avg_value_reg, avg_new, px16;
    logic signed [16:0]      avg_sum;
    logic                    out_valid_reg, load_out;
    logic [2:0]              status_reg;
    logic signed [11:0]      coord_x_reg, coord_y_reg;
    logic signed [15:0]      speed_x_reg, speed_y_reg, impact_x_reg, impact_time_reg;
    logic signed [15:0]      wall_y_reg;
    logic [9:0]              wall_x_reg;

    logic signed [10:0]      dx_y, dx_x;
    logic signed [V_W-1:0]   d_cy, wx_cx;
    logic signed [MA_W-1:0]  by_cy, d_by;
    logic signed [DV_W-1:0]  fm;
    logic                    noise, approach, in_walls;

    ptp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .p     (mul_p)
    );

    ptp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .busy  (div_busy),
        .q     (div_q)
    );

    // Operand terms and decisions.
    always_comb
    begin
        dx_y     = $signed({1'b0, pix_y_reg}) - $signed({1'b0, cfg.center_px_y});
        dx_x     = $signed({1'b0, pix_x_reg}) - $signed({1'b0, cfg.center_px_x});
        d_cy     = $signed({3'b000, cfg.defense_line}) - V_W'(cy_reg);
        wx_cx    = $signed({3'b000, wx_reg}) - V_W'(cx_reg);
        by_cy    = by_reg - MA_W'(cy_reg);
        d_by     = $signed({{(MA_W-10){1'b0}}, cfg.defense_line}) - by_reg;
        fm       = (cfg.frame_ms == 8'd0) ? DV_W'(1) : $signed({{(DV_W-8){1'b0}}, cfg.frame_ms});
        cy_new   = to_mm(mul_p, BASE_Y);
        noise    = (vx_reg > NL_P) || (vx_reg < NL_N) || (vy_reg > NL_P) || (vy_reg < NL_N);
        approach = spy_reg < APL;
        in_walls = (px_reg >= WL) && (px_reg <= WR);
        px16     = sat16(px_reg);
        avg_sum  = 17'(avg_value_reg) + 17'(px16);
        avg_new  = avg_valid_reg ? avg_sum[16:1] : px16;
        load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    // Sequencer: next state and arithmetic unit requests.
    always_comb
    begin
        state_next = state_reg;
        nxt        = state_reg;
        use_mul    = 1'b0;
        use_div    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_n      = '0;
        div_d      = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_MX;
            S_MX:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(dx_y);
                mul_b   = MB_W'($signed({1'b0, cfg.scale_x_q8}));
                nxt     = S_MY;
            end
            S_MY:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(dx_x);
                mul_b   = MB_W'($signed({1'b0, cfg.scale_y_q8}));
                nxt     = S_SX;
            end
            S_SX:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(vx_reg);
                mul_b   = HUNDRED;
                nxt     = S_DSX;
            end
            S_DSX:
            begin
                use_div = 1'b1;
                div_n   = mul_p;
                div_d   = fm;
                nxt     = S_SY;
            end
            S_SY:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(vy_reg);
                mul_b   = HUNDRED;
                nxt     = S_DSY;
            end
            S_DSY:
            begin
                use_div = 1'b1;
                div_n   = mul_p;
                div_d   = fm;
                nxt     = S_DEC;
            end
            S_DEC:
                state_next = (noise || !approach) ? S_DONE : S_P1;
            S_P1:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(d_cy);
                mul_b   = MB_W'(vx_reg);
                nxt     = S_P2;
            end
            S_P2:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(cx_reg);
                mul_b   = MB_W'(vy_reg);
                nxt     = S_P3;
            end
            S_P3:
            begin
                use_div = 1'b1;
                div_n   = tmp_reg;
                div_d   = DV_W'(vy_reg);
                nxt     = S_PSEL;
            end
            S_PSEL:
                state_next = ((vx_reg == '0) || in_walls) ? S_T1 : S_B1;
            S_B1:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(wx_cx);
                mul_b   = MB_W'(vy_reg);
                nxt     = S_B2;
            end
            S_B2:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(cy_reg);
                mul_b   = MB_W'(vx_reg);
                nxt     = S_B3;
            end
            S_B3:
            begin
                use_div = 1'b1;
                div_n   = tmp_reg;
                div_d   = DV_W'(vx_reg);
                nxt     = S_C1;
            end
            S_C1:
            begin
                use_mul = 1'b1;
                mul_a   = by_cy;
                mul_b   = HUNDRED;
                nxt     = S_C2;
            end
            S_C2:
            begin
                use_div = 1'b1;
                div_n   = mul_p;
                div_d   = DV_W'(spy_reg);
                nxt     = S_C3;
            end
            S_C3:
            begin
                use_mul = 1'b1;
                mul_a   = d_by;
                mul_b   = MB_W'(vx_reg);
                nxt     = S_C4;
            end
            S_C4:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'($signed({1'b0, wx_reg}));
                mul_b   = MB_W'(vy_reg);
                nxt     = S_C5;
            end
            S_C5:
            begin
                use_div = 1'b1;
                div_n   = tmp_reg;
                div_d   = DV_W'(vy_reg);
                nxt     = S_CSEL;
            end
            S_CSEL:
                state_next = in_walls ? S_T1 : S_DONE;
            S_T1:
            begin
                use_mul = 1'b1;
                mul_a   = MA_W'(d_cy);
                mul_b   = HUNDRED;
                nxt     = S_T2;
            end
            S_T2:
            begin
                use_div = 1'b1;
                div_n   = mul_p;
                div_d   = DV_W'(spy_reg);
                nxt     = S_DONE;
            end
            S_DONE:
                if (load_out)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        mul_start = use_mul && !issued_reg;
        div_start = use_div && !issued_reg;
        op_done   = issued_reg && ((use_mul && !mul_busy) || (use_div && !div_busy));
        if (op_done)
            state_next = nxt;
    end

    assign in_stall = (state_reg != S_IDLE);

    // Control and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            avg_valid_reg <= 1'b0;
            avg_value_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (op_done)
                issued_reg <= 1'b0;
            else if (mul_start || div_start)
                issued_reg <= 1'b1;
            if (op_done && (state_reg == S_MY))
            begin
                prev_x_reg <= cx_reg;
                prev_y_reg <= cy_new;
            end
            if ((state_reg == S_DEC) && !noise && !approach)
                avg_valid_reg <= 1'b0;
            if ((state_reg == S_CSEL) && !in_walls)
                avg_valid_reg <= 1'b0;
            if (op_done && (state_reg == S_T2))
            begin
                avg_valid_reg <= 1'b1;
                avg_value_reg <= avg_new;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath captures.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            pix_x_reg  <= pix_x;
            pix_y_reg  <= pix_y;
            bounce_reg <= 1'b0;
            res_ix_reg <= '0;
            res_it_reg <= '0;
        end
        if (state_reg == S_DEC)
            res_status_reg <= noise ? ST_NOISE : (approach ? ST_DIRECT : ST_AWAY);
        if ((state_reg == S_PSEL) && !((vx_reg == '0) || in_walls))
        begin
            res_status_reg <= ST_ONE;
            bounce_reg     <= 1'b1;
            wx_reg         <= (px_reg < WL) ? 10'(WALL_LEFT) : 10'(WALL_RIGHT);
        end
        if ((state_reg == S_CSEL) && !in_walls)
            res_status_reg <= ST_TWO;
        if (op_done)
        begin
            unique case (state_reg)
                S_MX:  cx_reg <= to_mm(mul_p, BASE_X);
                S_MY:
                begin
                    cy_reg <= cy_new;
                    vx_reg <= V_W'(cx_reg) - V_W'(prev_x_reg);
                    vy_reg <= V_W'(cy_new) - V_W'(prev_y_reg);
                end
                S_DSX: spx_reg <= SPD_W'(div_q);
                S_DSY: spy_reg <= SPD_W'(div_q);
                S_P1, S_B1: tmp_reg <= mul_p;
                S_P2, S_B2, S_C4: tmp_reg <= tmp_reg + mul_p;
                S_C3:  tmp_reg <= -mul_p;
                S_P3, S_C5: px_reg <= div_q;
                S_B3:  by_reg <= MA_W'(div_q);
                S_C2:  t1_reg <= div_q;
                S_T2:
                begin
                    res_ix_reg <= avg_new;
                    res_it_reg <= sat16(bounce_reg ? t1_reg + div_q : div_q);
                end
                default: ;
            endcase
        end
        if (load_out)
        begin
            status_reg      <= res_status_reg;
            coord_x_reg     <= cx_reg;
            coord_y_reg     <= cy_reg;
            speed_x_reg     <= sat16(P_W'(spx_reg));
            speed_y_reg     <= sat16(P_W'(spy_reg));
            impact_x_reg    <= res_ix_reg;
            impact_time_reg <= res_it_reg;
            if ((res_status_reg == ST_ONE) || (res_status_reg == ST_TWO))
            begin
                wall_x_reg <= wx_reg;
                wall_y_reg <= sat16(P_W'(by_reg));
            end
            else
            begin
                wall_x_reg <= '0;
                wall_y_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign coord_x     = coord_x_reg;
    assign coord_y     = coord_y_reg;
    assign speed_x     = speed_x_reg;
    assign speed_y     = speed_y_reg;
    assign impact_x    = impact_x_reg;
    assign impact_time = impact_time_reg;
    assign wall_x      = wall_x_reg;
    assign wall_y      = wall_y_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ptp_checker.sv =====
// ----------------------------------------------------------------------------
// ptp_port_checks
// Port-level checks of the puck trajectory predictor core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptp_port_checks (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pready,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [2:0]                    status,
    input wire logic signed [15:0]            impact_x,
    input wire logic signed [15:0]            impact_time,
    input wire logic [9:0]                    wall_x
);
    import ptp_pkg::*;

    logic        in_acc, out_hold, no_pred, no_impact, no_bounce;
    logic [18:0] held;

    // Conditions used by the assertions below.
    assign in_acc    = in_valid && !in_stall;
    assign out_hold  = out_valid && out_stall;
    assign held      = {status, impact_x};
    assign no_pred   = out_valid && (status != ST_DIRECT) && (status != ST_ONE);
    assign no_impact = (impact_x == 16'sd0) && (impact_time == 16'sd0);
    assign no_bounce = out_valid && (status != ST_ONE) && (status != ST_TWO);

    // The register port never inserts wait states.
    `PTP_ASSERT(a_pready, clk, rst_n, pready, "pready dropped")

    // An accepted request makes the core busy in the next cycle.
    `PTP_ASSERT_NXT(a_busy, clk, rst_n, in_acc, in_stall, "no busy after request")

    // A stalled result holds.
    `PTP_ASSERT_NXT(a_hold, clk, rst_n, out_hold, out_valid && $stable(held), "stalled result changed")

    // Impact fields are zero unless a prediction was made.
    `PTP_ASSERT_IMP(a_imp, clk, rst_n, no_pred, no_impact, "impact without prediction")

    // The wall x field only appears with a bounce.
    `PTP_ASSERT_IMP(a_wall, clk, rst_n, no_bounce, wall_x == 10'd0, "wall without bounce")

endmodule

bind puck_trajectory_predictor_core ptp_port_checks u_ptp_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .impact_x    (impact_x),
    .impact_time (impact_time),
    .wall_x      (wall_x)
);

`default_nettype wire
